// ===== hw/rtl/btc_pkg.sv =====
package btc_pkg;

    // Field widths
    localparam int ADC_W        = 24;
    localparam int ADC_BITS_DEF = 24;
    localparam int CAL_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int TEMP_W       = 19;
    localparam int SENS_W       = 42;
    localparam int OFF_W        = 43;

    // Internal widths
    localparam int REF_SHIFT = 8;                    // reference temp is C5 * 256
    localparam int DT_W      = 25;                   // temperature difference
    localparam int PROD_W    = CAL_W + 1 + DT_W;     // calibration word times dT
    localparam int DDSQ_W    = 2 * DT_W;             // dT squared
    localparam int T2_LSB    = 31;
    localparam int T2_W      = 18;                   // dT^2 / 2^31 stays below 2^18
    localparam int Q_LSB     = 23;                   // dT * C6 / 2^23
    localparam int SQ_W      = 35;                   // squares of temperature deviations

    // Scaling of the first-order terms
    localparam int SENS_SHIFT      = 7;
    localparam int OFF_SHIFT       = 6;
    localparam int SENS_BASE_SHIFT = 16;
    localparam int OFF_BASE_SHIFT  = 17;

    // Second-order correction
    localparam int TEMP_REF      = 2000;
    localparam int COLD_REF      = -1500;
    localparam int OFF2_MUL      = 61;
    localparam int OFF2_SHIFT    = 4;
    localparam int OFF2_COLD_MUL = 15;
    localparam int SENS2_MUL     = 2;
    localparam int SENS2_COLD_MUL = 8;

    // Pipeline depth
    localparam int NUM_STAGES = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CAL_PRESSURE_SENS   = 3'd0,
        CAL_PRESSURE_OFFSET = 3'd1,
        CAL_TC_SENS         = 3'd2,
        CAL_TC_OFFSET       = 3'd3,
        CAL_REF_TEMP        = 3'd4,
        CAL_TC_TEMP         = 3'd5
    } cal_idx_t;

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sens;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] tc_sens;
        logic [CAL_W-1:0] tc_offset;
        logic [CAL_W-1:0] ref_temp;
        logic [CAL_W-1:0] tc_temp;
    } cal_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

endpackage

// ===== hw/rtl/btc_adc_if.sv =====
interface btc_adc_if;

    logic                        valid;
    logic                        ready;
    logic [btc_pkg::ADC_W-1:0]   adc_temp;

    modport source (output valid, output adc_temp, input ready);
    modport sink   (input valid, input adc_temp, output ready);

endinterface

// ===== hw/rtl/btc_res_if.sv =====
interface btc_res_if;

    logic                               valid;
    logic                               ready;
    logic signed [btc_pkg::TEMP_W-1:0]  temp_centideg;
    logic signed [btc_pkg::SENS_W-1:0]  sens_term;
    logic signed [btc_pkg::OFF_W-1:0]   offset_term;

    modport source (output valid, output temp_centideg, output sens_term,
                    output offset_term, input ready);
    modport sink   (input valid, input temp_centideg, input sens_term,
                    input offset_term, output ready);

endinterface

// ===== hw/rtl/btc_cfg_if.sv =====
interface btc_cfg_if;

    logic                           valid;
    logic                           ready;
    logic [btc_pkg::CFG_IDX_W-1:0]  index;
    logic [btc_pkg::CAL_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// ===== hw/rtl/btc_cfg.sv =====
module btc_cfg
(
    input  logic            clk,
    input  logic            rst_n,
    btc_cfg_if.sink         cfg,
    output btc_pkg::cal_t   cal
);

    btc_pkg::cal_t cal_reg;
    btc_pkg::cal_t cal_next;

    // Always take writes; unknown indexes are dropped
    assign cfg.ready = 1'b1;
    assign cal       = cal_reg;

    // Decode the register index
    always_comb
    begin
        cal_next = cal_reg;
        if (cfg.valid)
        begin
            unique case (btc_pkg::cal_idx_t'(cfg.index))
                btc_pkg::CAL_PRESSURE_SENS:   cal_next.pressure_sens   = cfg.data;
                btc_pkg::CAL_PRESSURE_OFFSET: cal_next.pressure_offset = cfg.data;
                btc_pkg::CAL_TC_SENS:         cal_next.tc_sens         = cfg.data;
                btc_pkg::CAL_TC_OFFSET:       cal_next.tc_offset       = cfg.data;
                btc_pkg::CAL_REF_TEMP:        cal_next.ref_temp        = cfg.data;
                btc_pkg::CAL_TC_TEMP:         cal_next.tc_temp         = cfg.data;
                default:                      cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

endmodule

// ===== hw/rtl/btc_pipe_ctrl.sv =====
module btc_pipe_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output btc_pkg::pipe_ctrl_t   ctrl
);

    localparam int N = btc_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N:0]   rdy;

    // Stage takes an item when empty or when the stage after it moves
    always_comb
    begin
        rdy[N] = out_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i + 1];
        end
    end

    // Advance valid bits and load payload only where an item moves in
    always_comb
    begin
        ctrl.load[0]  = rdy[0] && in_valid;
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < N; i++)
        begin
            ctrl.load[i]  = rdy[i] && valid_reg[i - 1];
            valid_next[i] = rdy[i] ? valid_reg[i - 1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[N-1];

`ifndef SYNTHESIS
    a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !(&valid_reg) |-> in_ready)
        else $error("input stalled while the pipeline has a bubble");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !out_ready) |=> (&valid_reg))
        else $error("item lost from a stalled full pipeline");

    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(valid_reg) == $countones($past(valid_reg))
            + int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready))))
        else $error("items in flight do not match accepted and delivered items");
`endif

endmodule

// ===== hw/rtl/btc_datapath.sv =====
module btc_datapath
#(
    parameter int ADC_BITS = btc_pkg::ADC_BITS_DEF
)
(
    input  logic                                clk,
    input  btc_pkg::cal_t                       cal,
    input  btc_pkg::pipe_ctrl_t                 ctrl,
    input  logic [btc_pkg::ADC_W-1:0]           adc_temp,
    output logic signed [btc_pkg::TEMP_W-1:0]   temp_centideg,
    output logic signed [btc_pkg::SENS_W-1:0]   sens_term,
    output logic signed [btc_pkg::OFF_W-1:0]    offset_term
);

    localparam int DT_W   = btc_pkg::DT_W;
    localparam int PROD_W = btc_pkg::PROD_W;
    localparam int TEMP_W = btc_pkg::TEMP_W;
    localparam int SENS_W = btc_pkg::SENS_W;
    localparam int OFF_W  = btc_pkg::OFF_W;
    localparam int CAL_W  = btc_pkg::CAL_W;
    localparam int T2_W   = btc_pkg::T2_W;
    localparam int SQ_W   = btc_pkg::SQ_W;

    // Stage 1: temperature difference
    logic signed [DT_W-1:0]     s1_dt_reg, s1_dt_next;

    // Stage 2: products with dT
    logic signed [PROD_W-1:0]   s2_p_sens_reg, s2_p_sens_next;
    logic signed [PROD_W-1:0]   s2_p_off_reg, s2_p_off_next;
    logic signed [PROD_W-1:0]   s2_p_temp_reg, s2_p_temp_next;
    logic signed [2*DT_W-1:0]   s2_p_dd_reg, s2_p_dd_next;

    // Stage 3: first-order terms
    logic signed [SENS_W-1:0]   s3_sens_reg, s3_sens_next;
    logic signed [OFF_W-1:0]    s3_off_reg, s3_off_next;
    logic signed [TEMP_W-1:0]   s3_temp_reg, s3_temp_next;
    logic signed [TEMP_W-1:0]   s3_dev_reg, s3_dev_next;
    logic signed [TEMP_W-1:0]   s3_cold_dev_reg, s3_cold_dev_next;
    logic [T2_W-1:0]            s3_t2_reg, s3_t2_next;

    // Stage 4: squares of the deviations
    logic signed [SENS_W-1:0]   s4_sens_reg;
    logic signed [OFF_W-1:0]    s4_off_reg;
    logic signed [TEMP_W-1:0]   s4_temp_reg;
    logic [T2_W-1:0]            s4_t2_reg;
    logic                       s4_low_reg, s4_low_next;
    logic                       s4_cold_reg, s4_cold_next;
    logic [SQ_W-1:0]            s4_f_reg, s4_f_next;
    logic [SQ_W-1:0]            s4_f2_reg, s4_f2_next;

    // Stage 5: second-order corrections
    logic signed [SENS_W-1:0]   s5_sens_reg;
    logic signed [OFF_W-1:0]    s5_off_reg;
    logic signed [TEMP_W-1:0]   s5_temp_reg;
    logic [T2_W-1:0]            s5_t2_reg, s5_t2_next;
    logic [SENS_W-1:0]          s5_sens2_reg, s5_sens2_next;
    logic [OFF_W-1:0]           s5_off2_reg, s5_off2_next;

    // Stage 6: results
    logic signed [TEMP_W-1:0]   s6_temp_reg, s6_temp_next;
    logic signed [SENS_W-1:0]   s6_sens_reg, s6_sens_next;
    logic signed [OFF_W-1:0]    s6_off_reg, s6_off_next;

    // Helpers
    logic signed [CAL_W:0]      c_sens_s, c_off_s, c_temp_s;
    logic signed [SENS_W-1:0]   sens_frac;
    logic signed [OFF_W-1:0]    off_frac;
    logic signed [TEMP_W-1:0]   dev;
    logic signed [2*TEMP_W-1:0] f_full, f2_full;
    logic [OFF_W-1:0]           off2_warm, off2_cold;
    logic [SENS_W-1:0]          sens2_warm, sens2_cold;

    // Stage 1: dT = adc - C5 * 256, only the low ADC_BITS of the conversion
    always_comb
    begin
        s1_dt_next = $signed({{(DT_W-ADC_BITS){1'b0}}, adc_temp[ADC_BITS-1:0]})
                   - $signed({1'b0, cal.ref_temp, {btc_pkg::REF_SHIFT{1'b0}}});
    end

    // Stage 2: one multiplier per product
    always_comb
    begin
        c_sens_s       = $signed({1'b0, cal.tc_sens});
        c_off_s        = $signed({1'b0, cal.tc_offset});
        c_temp_s       = $signed({1'b0, cal.tc_temp});
        s2_p_sens_next = c_sens_s * s1_dt_reg;
        s2_p_off_next  = c_off_s * s1_dt_reg;
        s2_p_temp_next = c_temp_s * s1_dt_reg;
        s2_p_dd_next   = s1_dt_reg * s1_dt_reg;
    end

    // Stage 3: scale and offset the first-order terms
    always_comb
    begin
        sens_frac    = s2_p_sens_reg >>> btc_pkg::SENS_SHIFT;
        off_frac     = OFF_W'(s2_p_off_reg >>> btc_pkg::OFF_SHIFT);
        s3_sens_next = $signed({{(SENS_W-btc_pkg::SENS_BASE_SHIFT-CAL_W){1'b0}},
                                cal.pressure_sens, {btc_pkg::SENS_BASE_SHIFT{1'b0}}})
                     + sens_frac;
        s3_off_next  = $signed({{(OFF_W-btc_pkg::OFF_BASE_SHIFT-CAL_W){1'b0}},
                                cal.pressure_offset, {btc_pkg::OFF_BASE_SHIFT{1'b0}}})
                     + off_frac;
        // deviation from 20.00 C is the scaled product itself
        dev              = s2_p_temp_reg[btc_pkg::Q_LSB+TEMP_W-1:btc_pkg::Q_LSB];
        s3_dev_next      = dev;
        s3_temp_next     = dev + TEMP_W'(btc_pkg::TEMP_REF);
        s3_cold_dev_next = dev + TEMP_W'(btc_pkg::TEMP_REF - btc_pkg::COLD_REF);
        s3_t2_next       = s2_p_dd_reg[btc_pkg::T2_LSB+T2_W-1:btc_pkg::T2_LSB];
    end

    // Stage 4: square both deviations
    always_comb
    begin
        f_full       = s3_dev_reg * s3_dev_reg;
        f2_full      = s3_cold_dev_reg * s3_cold_dev_reg;
        s4_f_next    = f_full[SQ_W-1:0];
        s4_f2_next   = f2_full[SQ_W-1:0];
        s4_low_next  = s3_dev_reg[TEMP_W-1];
        s4_cold_next = s3_cold_dev_reg[TEMP_W-1];
    end

    // Stage 5: second-order corrections, zero at or above 20.00 C
    always_comb
    begin
        off2_warm  = (OFF_W'(s4_f_reg) * OFF_W'(btc_pkg::OFF2_MUL)) >> btc_pkg::OFF2_SHIFT;
        off2_cold  = OFF_W'(s4_f2_reg) * OFF_W'(btc_pkg::OFF2_COLD_MUL);
        sens2_warm = SENS_W'(s4_f_reg) * SENS_W'(btc_pkg::SENS2_MUL);
        sens2_cold = SENS_W'(s4_f2_reg) * SENS_W'(btc_pkg::SENS2_COLD_MUL);
        s5_off2_next  = '0;
        s5_sens2_next = '0;
        s5_t2_next    = '0;
        if (s4_low_reg)
        begin
            s5_off2_next  = off2_warm;
            s5_sens2_next = sens2_warm;
            s5_t2_next    = s4_t2_reg;
            if (s4_cold_reg)
            begin
                s5_off2_next  = off2_warm + off2_cold;
                s5_sens2_next = sens2_warm + sens2_cold;
            end
        end
    end

    // Stage 6: apply the corrections
    always_comb
    begin
        s6_temp_next = s5_temp_reg - $signed({1'b0, s5_t2_reg});
        s6_sens_next = s5_sens_reg - $signed(s5_sens2_reg);
        s6_off_next  = s5_off_reg - $signed(s5_off2_reg);
    end

    // Stage registers, loaded only when an item moves in
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s1_dt_reg <= s1_dt_next;
        end
        if (ctrl.load[1])
        begin
            s2_p_sens_reg <= s2_p_sens_next;
            s2_p_off_reg  <= s2_p_off_next;
            s2_p_temp_reg <= s2_p_temp_next;
            s2_p_dd_reg   <= s2_p_dd_next;
        end
        if (ctrl.load[2])
        begin
            s3_sens_reg     <= s3_sens_next;
            s3_off_reg      <= s3_off_next;
            s3_temp_reg     <= s3_temp_next;
            s3_dev_reg      <= s3_dev_next;
            s3_cold_dev_reg <= s3_cold_dev_next;
            s3_t2_reg       <= s3_t2_next;
        end
        if (ctrl.load[3])
        begin
            s4_sens_reg <= s3_sens_reg;
            s4_off_reg  <= s3_off_reg;
            s4_temp_reg <= s3_temp_reg;
            s4_t2_reg   <= s3_t2_reg;
            s4_low_reg  <= s4_low_next;
            s4_cold_reg <= s4_cold_next;
            s4_f_reg    <= s4_f_next;
            s4_f2_reg   <= s4_f2_next;
        end
        if (ctrl.load[4])
        begin
            s5_sens_reg  <= s4_sens_reg;
            s5_off_reg   <= s4_off_reg;
            s5_temp_reg  <= s4_temp_reg;
            s5_t2_reg    <= s5_t2_next;
            s5_sens2_reg <= s5_sens2_next;
            s5_off2_reg  <= s5_off2_next;
        end
        if (ctrl.load[5])
        begin
            s6_temp_reg <= s6_temp_next;
            s6_sens_reg <= s6_sens_next;
            s6_off_reg  <= s6_off_next;
        end
    end

    assign temp_centideg = s6_temp_reg;
    assign sens_term     = s6_sens_reg;
    assign offset_term   = s6_off_reg;

endmodule

// ===== hw/rtl/baro_temperature_compensation_unit.sv =====
// An accepted item moves through the stage registers in turn; the last one is the output register.
// Throughput: one item per cycle through the six-stage pipeline while the output is not stalled.
// A stalled output holds its item; empty stages upstream still fill.
// Reset (rst_n low, asynchronous) clears all stage valid bits and sets every
// calibration register to zero.
module baro_temperature_compensation_unit
#(
    parameter int ADC_BITS = btc_pkg::ADC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    btc_adc_if.sink     adc,
    btc_res_if.source   res,
    btc_cfg_if.sink     cfg
);

    btc_pkg::cal_t        cal;
    btc_pkg::pipe_ctrl_t  ctrl;

    // Calibration words
    btc_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cal   (cal)
    );

    // Valid bits and stage loads
    btc_pipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (adc.valid),
        .in_ready  (adc.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .ctrl      (ctrl)
    );

    // Compensation arithmetic
    btc_datapath #(
        .ADC_BITS (ADC_BITS)
    ) u_datapath
    (
        .clk           (clk),
        .cal           (cal),
        .ctrl          (ctrl),
        .adc_temp      (adc.adc_temp),
        .temp_centideg (res.temp_centideg),
        .sens_term     (res.sens_term),
        .offset_term   (res.offset_term)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int STALL_LIMIT     = 1000;
    localparam int SETTLE_CYCLES   = 2 * btc_pkg::NUM_STAGES + 4;
    localparam int REPORT_LIMIT    = 10;
    localparam int SWEEP_PHASES    = 10;
    localparam int SWEEP_ITEMS     = 124;
    localparam int ADC_USED        = btc_pkg::ADC_BITS_DEF;
    // a tc_temp of 2^15 makes the first-order temperature step by one per 256 counts
    localparam int UNIT_SLOPE_LOG2 = 15;

    localparam int ADC_W     = btc_pkg::ADC_W;
    localparam int CAL_W     = btc_pkg::CAL_W;
    localparam int CFG_IDX_W = btc_pkg::CFG_IDX_W;
    localparam int TEMP_W    = btc_pkg::TEMP_W;
    localparam int SENS_W    = btc_pkg::SENS_W;
    localparam int OFF_W     = btc_pkg::OFF_W;

    localparam logic [ADC_W-1:0]     ADC_MAX          = {ADC_W{1'b1}};
    localparam logic [CAL_W-1:0]     CAL_MAX          = {CAL_W{1'b1}};
    localparam logic [CFG_IDX_W-1:0] CAL_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CAL_IDX_SPARE_HI = 3'd7;
    localparam longint               ADC_MASK         = (longint'(1) << ADC_USED) - 1;

    // factory words and conversion of a typical part
    localparam btc_pkg::cal_t TYPICAL_CAL = '{
        pressure_sens:   16'd46372,
        pressure_offset: 16'd43981,
        tc_sens:         16'd29059,
        tc_offset:       16'd27842,
        ref_temp:        16'd31553,
        tc_temp:         16'd28165
    };
    localparam logic [ADC_W-1:0] TYPICAL_ADC = 24'd8569150;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [SENS_W-1:0] sens;
        logic signed [OFF_W-1:0]  off;
    } comp_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    btc_adc_if adc_if ();
    btc_res_if res_if ();
    btc_cfg_if cfg_if ();

    btc_pkg::cal_t cal_words;
    comp_result_t  pending_results [$];
    int            mismatch_count = 0;
    int            idle_cycles    = 0;
    bit            src_steady     = 1'b0;
    bit            sink_steady    = 1'b0;

    baro_temperature_compensation_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .adc   (adc_if.sink),
        .res   (res_if.source),
        .cfg   (cfg_if.sink)
    );

    always #HALF_PERIOD clk = ~clk;

    // Pick an idle gap: mostly none or short, now and then long
    function automatic int pick_gap(input bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Compute the compensated temperature, sensitivity and offset of one conversion
    function automatic comp_result_t compensate(input logic [ADC_W-1:0] raw);
        longint       adc_val;
        longint       dt;
        longint       sens_acc;
        longint       off_acc;
        longint       deg;
        longint       t2;
        longint       dev_sq;
        longint       cold_sq;
        longint       sens2;
        longint       off2;
        comp_result_t r;
        adc_val  = longint'(raw) & ADC_MASK;
        dt       = adc_val - (longint'(cal_words.ref_temp) << btc_pkg::REF_SHIFT);
        sens_acc = (longint'(cal_words.pressure_sens) << btc_pkg::SENS_BASE_SHIFT)
                 + ((longint'(cal_words.tc_sens) * dt) >>> btc_pkg::SENS_SHIFT);
        off_acc  = (longint'(cal_words.pressure_offset) << btc_pkg::OFF_BASE_SHIFT)
                 + ((longint'(cal_words.tc_offset) * dt) >>> btc_pkg::OFF_SHIFT);
        deg      = btc_pkg::TEMP_REF
                 + ((dt * longint'(cal_words.tc_temp)) >>> btc_pkg::Q_LSB);
        // second-order correction below the reference temperature
        if (deg < btc_pkg::TEMP_REF)
        begin
            t2     = (dt * dt) >>> btc_pkg::T2_LSB;
            dev_sq = (deg - btc_pkg::TEMP_REF) * (deg - btc_pkg::TEMP_REF);
            off2   = (btc_pkg::OFF2_MUL * dev_sq) >>> btc_pkg::OFF2_SHIFT;
            sens2  = btc_pkg::SENS2_MUL * dev_sq;
            // extra term in the cold range
            if (deg < btc_pkg::COLD_REF)
            begin
                cold_sq = (deg - btc_pkg::COLD_REF) * (deg - btc_pkg::COLD_REF);
                off2    = off2 + btc_pkg::OFF2_COLD_MUL * cold_sq;
                sens2   = sens2 + btc_pkg::SENS2_COLD_MUL * cold_sq;
            end
            deg      = deg - t2;
            sens_acc = sens_acc - sens2;
            off_acc  = off_acc - off2;
        end
        r.temp = deg[TEMP_W-1:0];
        r.sens = sens_acc[SENS_W-1:0];
        r.off  = off_acc[OFF_W-1:0];
        return r;
    endfunction

    // Pick a conversion: full range, around the reference, or near either end
    function automatic logic [ADC_W-1:0] pick_adc();
        int     roll;
        longint spot;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return ADC_W'($urandom());
        if (roll < 8)
        begin
            spot = (longint'(cal_words.ref_temp) << btc_pkg::REF_SHIFT)
                 + longint'($urandom_range(0, 65536)) - 32768;
            if (spot < 0)
                spot = 0;
            if (spot > ADC_MASK)
                spot = ADC_MASK;
            return spot[ADC_W-1:0];
        end
        if (roll == 8)
            return ADC_W'($urandom_range(0, 255));
        return ADC_MAX - ADC_W'($urandom_range(0, 255));
    endfunction

    // Send one conversion and queue its expected result once taken
    task automatic send_adc(input logic [ADC_W-1:0] value);
        int gap;
        gap = pick_gap(src_steady);
        @(negedge clk);
        if (gap > 0)
        begin
            adc_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        adc_if.valid    <= 1'b1;
        adc_if.adc_temp <= value;
        do
        begin
            @(posedge clk);
        end
        while (!adc_if.ready);
        pending_results.push_back(compensate(value));
    endtask

    // Drop valid and hold until every queued result has come back
    task automatic wait_for_results();
        @(negedge clk);
        adc_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write one calibration word and mirror it in the local copy
    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
        int gap;
        gap = pick_gap(src_steady);
        repeat (gap) @(negedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        case (idx)
            btc_pkg::CAL_PRESSURE_SENS:   cal_words.pressure_sens   = value;
            btc_pkg::CAL_PRESSURE_OFFSET: cal_words.pressure_offset = value;
            btc_pkg::CAL_TC_SENS:         cal_words.tc_sens         = value;
            btc_pkg::CAL_TC_OFFSET:       cal_words.tc_offset       = value;
            btc_pkg::CAL_REF_TEMP:        cal_words.ref_temp        = value;
            btc_pkg::CAL_TC_TEMP:         cal_words.tc_temp         = value;
            default:                      ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic load_cal(input btc_pkg::cal_t words);
        write_cal(btc_pkg::CAL_PRESSURE_SENS,   words.pressure_sens);
        write_cal(btc_pkg::CAL_PRESSURE_OFFSET, words.pressure_offset);
        write_cal(btc_pkg::CAL_TC_SENS,         words.tc_sens);
        write_cal(btc_pkg::CAL_TC_OFFSET,       words.tc_offset);
        write_cal(btc_pkg::CAL_REF_TEMP,        words.ref_temp);
        write_cal(btc_pkg::CAL_TC_TEMP,         words.tc_temp);
    endtask

    // All words zero after reset: constant output
    task automatic test_reset_defaults();
        send_adc('0);
        send_adc(ADC_MAX);
        send_adc(ADC_W'($urandom()));
        wait_for_results();
    endtask

    task automatic test_typical_part();
        load_cal(TYPICAL_CAL);
        send_adc(TYPICAL_ADC);
        send_adc(ADC_W'(longint'(TYPICAL_CAL.ref_temp) << btc_pkg::REF_SHIFT));
        send_adc('0);
        send_adc(ADC_MAX);
        wait_for_results();
    endtask

    // Land exactly on and just below 20.00 C and -15.00 C
    task automatic test_threshold_edges();
        btc_pkg::cal_t words;
        longint        centre;
        longint        cold_dt;
        words          = TYPICAL_CAL;
        words.ref_temp = CAL_W'(1 << (CAL_W - 1));
        words.tc_temp  = CAL_W'(1 << UNIT_SLOPE_LOG2);
        load_cal(words);
        centre  = longint'(words.ref_temp) << btc_pkg::REF_SHIFT;
        cold_dt = longint'(btc_pkg::COLD_REF - btc_pkg::TEMP_REF)
                  << (btc_pkg::Q_LSB - UNIT_SLOPE_LOG2);
        send_adc(ADC_W'(centre));
        send_adc(ADC_W'(centre - 1));
        send_adc(ADC_W'(centre + cold_dt));
        send_adc(ADC_W'(centre + cold_dt - 1));
        wait_for_results();
    endtask

    // Corners of the calibration words: hottest, coldest, most negative terms
    task automatic test_cal_extremes();
        btc_pkg::cal_t words;
        words = '{default: CAL_MAX};
        load_cal(words);
        send_adc('0);
        send_adc(ADC_MAX);
        wait_for_results();

        words = '0;
        words.ref_temp  = CAL_MAX;
        words.tc_sens   = CAL_MAX;
        words.tc_offset = CAL_MAX;
        load_cal(words);
        send_adc('0);
        wait_for_results();

        words = '{default: CAL_MAX};
        words.ref_temp = '0;
        load_cal(words);
        send_adc(ADC_MAX);
        wait_for_results();

        words = '{default: CAL_MAX};
        words.pressure_sens   = '0;
        words.pressure_offset = '0;
        load_cal(words);
        send_adc('0);
        wait_for_results();
    endtask

    // Writes to unused indexes must leave every word alone
    task automatic test_cal_index_range();
        load_cal(TYPICAL_CAL);
        write_cal(CAL_IDX_SPARE_LO, CAL_W'($urandom()));
        write_cal(CAL_IDX_SPARE_HI, CAL_W'($urandom()));
        send_adc(TYPICAL_ADC);
        send_adc(ADC_W'($urandom()));
        wait_for_results();
    endtask

    // Random conversions over a series of calibration sets
    task automatic test_random_sweep();
        btc_pkg::cal_t words;
        for (int phase = 0; phase < SWEEP_PHASES; phase++)
        begin
            words.pressure_sens   = CAL_W'($urandom());
            words.pressure_offset = CAL_W'($urandom());
            words.tc_sens         = CAL_W'($urandom());
            words.tc_offset       = CAL_W'($urandom());
            words.ref_temp        = CAL_W'($urandom());
            words.tc_temp         = CAL_W'($urandom());
            case (phase)
                0: words = '{default: CAL_MAX};
                1:
                begin
                    words          = '0;
                    words.ref_temp = CAL_W'($urandom());
                    words.tc_temp  = CAL_MAX;
                end
                4: words.ref_temp = '0;
                6: words.ref_temp = CAL_MAX;
                default: ;
            endcase
            src_steady  = (phase % 4 == 3);
            sink_steady = (phase % 4 == 3);
            load_cal(words);
            for (int n = 0; n < SWEEP_ITEMS; n++)
                send_adc(pick_adc());
            wait_for_results();
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // Pace the result side: ready runs broken by stalls
    initial
    begin : sink_pacing
        int stall;
        int run;
        res_if.ready = 1'b0;
        forever
        begin
            stall = pick_gap(sink_steady);
            if (stall > 0)
            begin
                @(negedge clk);
                res_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            res_if.ready <= 1'b1;
            run = sink_steady ? 1 : $urandom_range(1, 8);
            repeat (run - 1) @(negedge clk);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        comp_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: temp %0d sens %0d off %0d",
                             res_if.temp_centideg, res_if.sens_term, res_if.offset_term);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_if.temp_centideg !== want.temp || res_if.sens_term !== want.sens
                    || res_if.offset_term !== want.off)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"mismatch: temp exp %0d got %0d, ",
                                  "sens exp %0d got %0d, off exp %0d got %0d"},
                                 want.temp, res_if.temp_centideg, want.sens, res_if.sens_term,
                                 want.off, res_if.offset_term);
                end
            end
        end
    end

    // Stop a hung run: too many cycles with nothing taken on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (adc_if.valid && adc_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        adc_if.valid    = 1'b0;
        adc_if.adc_temp = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        cal_words       = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_typical_part();
        test_threshold_edges();
        test_cal_extremes();
        test_cal_index_range();
        test_random_sweep();

        // let stray results show up before the verdict
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
